// File: hw/rtl/tdts_pkg.sv
// ----------------------------------------------------------------------------
// tdts_pkg
// Shared widths, command and mode codes, and the compare-unit control bundle.
// ----------------------------------------------------------------------------
package tdts_pkg;

    localparam int TASK_IDX_W = 3;
    localparam int VALUE_W    = 16;
    localparam int OUT_CNT_W  = 16;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic MODE_SJF  = 1'b0;
    localparam logic MODE_PRIO = 1'b1;

    typedef struct packed {
        logic mode;
        logic eligible;
        logic best_none;
    } cmp_ctrl_t;

endpackage

// File: hw/rtl/tdts_in_if.sv
// ----------------------------------------------------------------------------
// tdts_in_if
// Request channel: tick or task-load items.
// ----------------------------------------------------------------------------
interface tdts_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [tdts_pkg::TASK_IDX_W-1:0]   task_index;
    logic [tdts_pkg::VALUE_W-1:0]      priority_value;
    logic [tdts_pkg::VALUE_W-1:0]      refill_value;

    modport source (output valid, output cmd, output task_index,
                    output priority_value, output refill_value, input ready);
    modport sink   (input valid, input cmd, input task_index,
                    input priority_value, input refill_value, output ready);
endinterface

// File: hw/rtl/tdts_out_if.sv
// ----------------------------------------------------------------------------
// tdts_out_if
// Response channel: one scheduling result per request.
// ----------------------------------------------------------------------------
interface tdts_out_if;
    logic                              valid;
    logic                              ready;
    logic                              switched;
    logic [tdts_pkg::TASK_IDX_W-1:0]   running_task;
    logic [tdts_pkg::OUT_CNT_W-1:0]    running_counter;
    logic                              stuck;

    modport source (output valid, output switched, output running_task,
                    output running_counter, output stuck, input ready);
    modport sink   (input valid, input switched, input running_task,
                    input running_counter, input stuck, output ready);
endinterface

// File: hw/rtl/tdts_cfg_if.sv
// ----------------------------------------------------------------------------
// tdts_cfg_if
// Configuration write channel for the policy mode register.
// ----------------------------------------------------------------------------
interface tdts_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tick_driven_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// tick_driven_task_scheduler_top
// Task table with time-slice counters; picks the next task on timer ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one item per transfer; cmd selects timer tick or task load.
//   rsp  : exactly one result per request, in order, held in an output
//          register until the receiver takes it.
//   cfg  : policy mode writes, always ready; write only while idle.
// Sequence (N = NUM_TASKS):
//   load, or a tick that leaves the running task in place: straight to the
//   result stage. A tick with a pick scans tasks 1 to N-1, with a refill
//   pass twice. A request is taken only once the last result is in the output register.
//   The scan reads one table entry per cycle through the counter and
//   parameter RAM read ports into a single compare unit; a refill pass
//   rewrites counters and re-evaluates in the same sweep.
// A new request is taken while an earlier result still waits; a finished
// result stays internal until the output register frees, so a stalled
// receiver stalls the scheduler only after one item.
// Reset: all tasks invalid, idle task running, priority mode, no result
// pending. Table RAMs need no clearing; valid bits mask stale entries.
// ----------------------------------------------------------------------------
module tick_driven_task_scheduler_top #(
    parameter int NUM_TASKS  = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tdts_in_if.sink     req,
    tdts_out_if.source  rsp,
    tdts_cfg_if.sink    cfg
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int VW = tdts_pkg::VALUE_W;
    localparam int PW = 2 * VW;
    localparam int KW = (COUNT_BITS > VW) ? COUNT_BITS : VW;

    localparam logic [IW-1:0] IDLE_TASK = '0;
    localparam logic [IW-1:0] FIRST_IDX = IW'(1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_TASKS - 1);
    localparam logic [KW-1:0] CNT_MAX   = KW'({COUNT_BITS{1'b1}});

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // control state
    logic [1:0]            state_reg,     state_next;
    logic                  mode_reg,      mode_next;
    logic [NUM_TASKS-1:0]  valid_reg,     valid_next;
    logic [IW-1:0]         cur_reg,       cur_next;
    logic [COUNT_BITS-1:0] cur_cnt_reg,   cur_cnt_next;
    logic [IW-1:0]         prev_reg,      prev_next;
    logic [IW-1:0]         scan_idx_reg,  scan_idx_next;
    logic                  issue_reg,     issue_next;
    logic                  cmp_vld_reg,   cmp_vld_next;
    logic                  pass_reg,      pass_next;
    logic [IW-1:0]         best_reg,      best_next;
    logic                  sw_reg,        sw_next;
    logic                  stuck_reg,     stuck_next;
    logic                  out_valid_reg, out_valid_next;

    // payload
    logic [IW-1:0]         cmp_idx_reg,   cmp_idx_next;
    logic [KW-1:0]         best_key_reg,  best_key_next;
    logic [COUNT_BITS-1:0] best_cnt_reg,  best_cnt_next;
    logic                  out_sw_reg,    out_sw_next;
    logic [tdts_pkg::TASK_IDX_W-1:0] out_task_reg, out_task_next;
    logic [tdts_pkg::OUT_CNT_W-1:0]  out_cnt_reg,  out_cnt_next;
    logic                  out_stuck_reg, out_stuck_next;

    // RAM ports
    logic                  cnt_we;
    logic [IW-1:0]         cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  par_we;
    logic [IW-1:0]         ld_addr;
    logic                  rd_en;
    logic [COUNT_BITS-1:0] cnt_q;
    logic [PW-1:0]         par_q;

    // compare stage
    logic                  entry_valid;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [VW-1:0]         fill_src;
    logic [KW-1:0]         fill_ext;
    logic [COUNT_BITS-1:0] fill_cnt;
    logic [COUNT_BITS-1:0] cand_cnt;
    tdts_pkg::cmp_ctrl_t   cmp_ctrl;
    logic                  take;
    logic [KW-1:0]         new_key;
    logic [IW-1:0]         win_idx;
    logic [COUNT_BITS-1:0] win_cnt;
    logic [COUNT_BITS-1:0] dec_cnt;
    logic                  accept;
    logic                  ld_in_range;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;

    assign rsp.valid           = out_valid_reg;
    assign rsp.switched        = out_sw_reg;
    assign rsp.running_task    = out_task_reg;
    assign rsp.running_counter = out_cnt_reg;
    assign rsp.stuck           = out_stuck_reg;

    assign ld_addr     = IW'(req.task_index);
    assign ld_in_range = int'(req.task_index) < NUM_TASKS;
    assign dec_cnt     = (cur_cnt_reg == '0) ? '0 : cur_cnt_reg - COUNT_BITS'(1);

    tdts_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_TASKS)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (cnt_q)
    );

    // {priority, refill}
    tdts_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_TASKS)
    ) u_par_ram (
        .clk     (clk),
        .wr_en   (par_we),
        .wr_addr (ld_addr),
        .wr_data ({req.priority_value, req.refill_value}),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (par_q)
    );

    assign entry_valid = valid_reg[cmp_idx_reg];
    assign cnt_rd      = entry_valid ? cnt_q : '0;
    assign fill_src    = (mode_reg == tdts_pkg::MODE_PRIO) ? par_q[PW-1:VW] : par_q[VW-1:0];
    assign fill_ext    = KW'(fill_src);
    assign fill_cnt    = (fill_ext > CNT_MAX) ? COUNT_BITS'(CNT_MAX) : COUNT_BITS'(fill_ext);
    // refill pass evaluates the freshly refilled counter
    assign cand_cnt    = pass_reg ? fill_cnt : cnt_rd;

    assign cmp_ctrl.mode      = mode_reg;
    assign cmp_ctrl.eligible  = entry_valid && (cand_cnt != '0);
    assign cmp_ctrl.best_none = (best_reg == IDLE_TASK);

    tdts_cmp #(
        .KW (KW)
    ) u_cmp (
        .ctrl      (cmp_ctrl),
        .cand_cnt  (KW'(cand_cnt)),
        .cand_prio (KW'(par_q[PW-1:VW])),
        .key       (best_key_reg),
        .take      (take),
        .new_key   (new_key)
    );

    assign win_idx = take ? cmp_idx_reg : best_reg;
    assign win_cnt = take ? cand_cnt : best_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        valid_next     = valid_reg;
        cur_next       = cur_reg;
        cur_cnt_next   = cur_cnt_reg;
        prev_next      = prev_reg;
        scan_idx_next  = scan_idx_reg;
        issue_next     = issue_reg;
        cmp_vld_next   = 1'b0;
        pass_next      = pass_reg;
        best_next      = best_reg;
        sw_next        = sw_reg;
        stuck_next     = stuck_reg;
        out_valid_next = out_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        best_key_next  = best_key_reg;
        best_cnt_next  = best_cnt_reg;
        out_sw_next    = out_sw_reg;
        out_task_next  = out_task_reg;
        out_cnt_next   = out_cnt_reg;
        out_stuck_next = out_stuck_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = cur_reg;
        cnt_wdata      = dec_cnt;
        par_we         = 1'b0;
        rd_en          = 1'b0;

        if (cfg.valid)
        begin
            mode_next = cfg.data;
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sw_next    = 1'b0;
                    stuck_next = 1'b0;
                    prev_next  = cur_reg;
                    if (req.cmd == tdts_pkg::CMD_LOAD)
                    begin
                        state_next = S_DONE;
                        if (ld_in_range)
                        begin
                            valid_next[ld_addr] = 1'b1;
                            par_we    = 1'b1;
                            cnt_we    = 1'b1;
                            cnt_waddr = ld_addr;
                            cnt_wdata = '0;
                            if (ld_addr == cur_reg)
                            begin
                                cur_cnt_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        if (cur_reg != IDLE_TASK)
                        begin
                            cnt_we       = 1'b1;
                            cur_cnt_next = dec_cnt;
                        end
                        if (cur_reg == IDLE_TASK || dec_cnt == '0)
                        begin
                            state_next    = S_SCAN;
                            scan_idx_next = FIRST_IDX;
                            issue_next    = 1'b1;
                            pass_next     = 1'b0;
                            best_next     = IDLE_TASK;
                            best_key_next = '0;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (issue_reg)
                begin
                    rd_en        = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IW'(1);
                    end
                end

                if (cmp_vld_reg)
                begin
                    if (pass_reg && entry_valid)
                    begin
                        cnt_we    = 1'b1;
                        cnt_waddr = cmp_idx_reg;
                        cnt_wdata = fill_cnt;
                    end
                    if (take)
                    begin
                        best_next     = cmp_idx_reg;
                        best_key_next = new_key;
                        best_cnt_next = cand_cnt;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        if (win_idx != IDLE_TASK)
                        begin
                            cur_next     = win_idx;
                            cur_cnt_next = win_cnt;
                            sw_next      = (win_idx != prev_reg);
                            stuck_next   = 1'b0;
                            state_next   = S_DONE;
                        end
                        else if (!pass_reg)
                        begin
                            // nothing eligible: refill and scan again
                            pass_next     = 1'b1;
                            issue_next    = 1'b1;
                            scan_idx_next = FIRST_IDX;
                            best_key_next = '0;
                        end
                        else
                        begin
                            // idle task counter is never refilled, stays zero
                            cur_next     = IDLE_TASK;
                            cur_cnt_next = '0;
                            sw_next      = (prev_reg != IDLE_TASK);
                            stuck_next   = 1'b1;
                            state_next   = S_DONE;
                        end
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sw_next    = sw_reg;
                    out_task_next  = tdts_pkg::TASK_IDX_W'(cur_reg);
                    out_cnt_next   = tdts_pkg::OUT_CNT_W'(cur_cnt_reg);
                    out_stuck_next = stuck_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= tdts_pkg::MODE_PRIO;
            valid_reg     <= '0;
            cur_reg       <= IDLE_TASK;
            cur_cnt_reg   <= '0;
            prev_reg      <= IDLE_TASK;
            scan_idx_reg  <= FIRST_IDX;
            issue_reg     <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            pass_reg      <= 1'b0;
            best_reg      <= IDLE_TASK;
            sw_reg        <= 1'b0;
            stuck_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            valid_reg     <= valid_next;
            cur_reg       <= cur_next;
            cur_cnt_reg   <= cur_cnt_next;
            prev_reg      <= prev_next;
            scan_idx_reg  <= scan_idx_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            pass_reg      <= pass_next;
            best_reg      <= best_next;
            sw_reg        <= sw_next;
            stuck_reg     <= stuck_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        best_key_reg  <= best_key_next;
        best_cnt_reg  <= best_cnt_next;
        out_sw_reg    <= out_sw_next;
        out_task_reg  <= out_task_next;
        out_cnt_reg   <= out_cnt_next;
        out_stuck_reg <= out_stuck_next;
    end

endmodule

// File: hw/rtl/tdts_ram.sv
// ----------------------------------------------------------------------------
// tdts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/tdts_cmp.sv
// ----------------------------------------------------------------------------
// tdts_cmp
// Shared candidate-versus-best compare unit used by every scan step.
// ----------------------------------------------------------------------------
module tdts_cmp #(
    parameter int KW = 16
) (
    input  tdts_pkg::cmp_ctrl_t ctrl,
    input  logic [KW-1:0]       cand_cnt,
    input  logic [KW-1:0]       cand_prio,
    input  logic [KW-1:0]       key,
    output logic                take,
    output logic [KW-1:0]       new_key
);

    logic [KW-1:0] lhs;
    logic [KW-1:0] rhs;
    logic          lt;

    // priority: key < prio; SJF: cnt < key
    assign lhs     = (ctrl.mode == tdts_pkg::MODE_PRIO) ? key : cand_cnt;
    assign rhs     = (ctrl.mode == tdts_pkg::MODE_PRIO) ? cand_prio : key;
    assign lt      = lhs < rhs;
    assign new_key = (ctrl.mode == tdts_pkg::MODE_PRIO) ? cand_prio : cand_cnt;

    always_comb
    begin
        if (!ctrl.eligible)
        begin
            take = 1'b0;
        end
        else if (ctrl.mode == tdts_pkg::MODE_PRIO)
        begin
            take = lt;
        end
        else
        begin
            take = ctrl.best_none || lt;
        end
    end

endmodule

// File: hw/rtl/tdts_checker.sv
// ----------------------------------------------------------------------------
// tdts_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tdts_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic                              rsp_switched,
    input logic [tdts_pkg::TASK_IDX_W-1:0]   rsp_task,
    input logic [tdts_pkg::OUT_CNT_W-1:0]    rsp_counter,
    input logic                              rsp_stuck
);

    // stalled result keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid &&
        $stable({rsp_switched, rsp_task, rsp_counter, rsp_stuck}))
        else $error("rsp payload changed while stalled");

    // stuck always falls back to the idle task, whose counter is zero
    a_stuck_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stuck |-> (rsp_task == '0) && (rsp_counter == '0))
        else $error("stuck result not on idle task");

    // one request at a time: busy right after a transfer
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req accepted on consecutive cycles");

endmodule

bind tick_driven_task_scheduler_top tdts_checker u_tdts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_switched (rsp.switched),
    .rsp_task     (rsp.running_task),
    .rsp_counter  (rsp.running_counter),
    .rsp_stuck    (rsp.stuck)
);
